/* src/uttq_pkg.sv */
package uttq_pkg;

	typedef enum logic [1:0] {
		OP_EVENT = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef logic [7:0] byte_t;

	// request to one queue for the current transaction
	typedef struct packed {
		logic  push;
		logic  pop;
		byte_t data;
	} fifo_ctrl_t;

	// queue state before the transaction, and what the request did
	typedef struct packed {
		logic empty;
		logic full;
		logic push_ok;
		logic pop_ok;
	} fifo_stat_t;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 24;

endpackage

/* src/uttq_cell.sv */
module uttq_cell (
	input  logic            clk,
	input  logic            shift,
	input  logic            load,
	input  uttq_pkg::byte_t din,
	input  uttq_pkg::byte_t nxt,
	output uttq_pkg::byte_t dout
);

	uttq_pkg::byte_t data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end else if (shift) begin
			data_q <= nxt;
		end
	end

	assign dout = data_q;

endmodule

/* src/uttq_fifo.sv */
module uttq_fifo #(
	parameter int unsigned DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  uttq_pkg::fifo_ctrl_t ctrl,
	output uttq_pkg::fifo_stat_t stat,
	output uttq_pkg::byte_t      pop_data
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]   fill_q;
	uttq_pkg::byte_t cell_data [DEPTH];
	logic            empty;
	logic            full;
	logic            push_ok;
	logic            pop_ok;

	assign empty   = (fill_q == '0);
	assign full    = (fill_q == CW'(DEPTH));
	assign push_ok = ctrl.push && !full;
	// push happens first, so an empty queue can pop the byte pushed in the same transaction
	assign pop_ok  = ctrl.pop && (!empty || push_ok);

	assign stat.empty   = empty;
	assign stat.full    = full;
	assign stat.push_ok = push_ok;
	assign stat.pop_ok  = pop_ok;

	assign pop_data = empty ? ctrl.data : cell_data[0];

	// head sits in cell 0; a pop moves every cell one step toward the head
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		uttq_pkg::byte_t nxt;
		logic            load;

		if (i == DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end

		assign load = push_ok && (pop_ok ? (fill_q == CW'(i + 1)) : (fill_q == CW'(i)));

		uttq_cell u_cell (
			.clk  (clk),
			.shift(pop_ok),
			.load (load),
			.din  (ctrl.data),
			.nxt  (nxt),
			.dout (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push_ok && !pop_ok) begin
			fill_q <= fill_q + CW'(1);
		end else if (pop_ok && !push_ok) begin
			fill_q <= fill_q - CW'(1);
		end
	end

endmodule

/* src/uart_tty_echo_queues.sv */
// Tty buffering in front of a UART: receive, echo and transmit byte queues, each
// QUEUE_DEPTH bytes, built as a chain of byte cells with the head in the first cell;
// a dequeue shifts the whole chain one cell toward the head. Every input transaction
// (UART event, software write, software read) gives exactly one result transaction
// in the cycle after its acceptance, from an output register, so the block takes one
// item per clock while the output side is ready. Software reads and writes never
// block: read_valid or write_accepted low means retry. Echo (cfg_data) resets to on;
// the user must write it only while the block is idle, which the block does not enforce.
module uart_tty_echo_queues #(
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [0] rx_ready, [1] tx_empty, [9:2] rx_byte, [17:10] write_byte, rest zero
	input  logic [uttq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [1:0] op
	input  logic [1:0]                         s_axis_tuser,
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] tx_valid, [8:1] tx_byte, [9] read_valid, [17:10] read_byte,
	// [18] write_accepted, [19] tx_irq_enable, [20] rx_dropped, rest zero
	output logic [uttq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_data
);

	uttq_pkg::op_t        op;
	logic                 accept;
	logic                 is_event;
	logic                 rx_ready;
	logic                 tx_empty;
	uttq_pkg::byte_t      rx_byte;
	uttq_pkg::byte_t      write_byte;

	uttq_pkg::fifo_ctrl_t rx_ctrl;
	uttq_pkg::fifo_ctrl_t echo_ctrl;
	uttq_pkg::fifo_ctrl_t tx_ctrl;
	uttq_pkg::fifo_stat_t rx_st;
	uttq_pkg::fifo_stat_t echo_st;
	uttq_pkg::fifo_stat_t tx_st;
	uttq_pkg::byte_t      rx_pop_data;
	uttq_pkg::byte_t      echo_pop_data;
	uttq_pkg::byte_t      tx_pop_data;

	logic                                 echo_en_q;
	logic                                 tx_int_q;
	logic                                 tx_int_d;
	logic                                 sent;
	logic [uttq_pkg::OUT_DATA_W-1:0]      res_data;
	logic                                 res_last;
	logic                                 out_valid_q;
	logic [uttq_pkg::OUT_DATA_W-1:0]      out_data_q;
	logic                                 out_last_q;

	assign op         = uttq_pkg::op_t'(s_axis_tuser);
	assign rx_ready   = s_axis_tdata[0];
	assign tx_empty   = s_axis_tdata[1];
	assign rx_byte    = s_axis_tdata[9:2];
	assign write_byte = s_axis_tdata[17:10];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_event      = accept && (op == uttq_pkg::OP_EVENT);
	assign cfg_ready     = 1'b1;

	assign rx_ctrl.push   = is_event && rx_ready;
	assign rx_ctrl.pop    = accept && (op == uttq_pkg::OP_READ);
	assign rx_ctrl.data   = rx_byte;
	assign echo_ctrl.push = is_event && rx_ready && echo_en_q;
	assign echo_ctrl.pop  = is_event && tx_empty;
	assign echo_ctrl.data = rx_byte;
	assign tx_ctrl.push   = accept && (op == uttq_pkg::OP_WRITE);
	// transmit queue only sends when the echo queue sends nothing
	assign tx_ctrl.pop    = is_event && tx_empty && !echo_st.pop_ok;
	assign tx_ctrl.data   = write_byte;

	uttq_fifo #(.DEPTH(QUEUE_DEPTH)) u_rx_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (rx_ctrl),
		.stat    (rx_st),
		.pop_data(rx_pop_data)
	);

	uttq_fifo #(.DEPTH(QUEUE_DEPTH)) u_echo_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (echo_ctrl),
		.stat    (echo_st),
		.pop_data(echo_pop_data)
	);

	uttq_fifo #(.DEPTH(QUEUE_DEPTH)) u_tx_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (tx_ctrl),
		.stat    (tx_st),
		.pop_data(tx_pop_data)
	);

	assign sent = echo_st.pop_ok || tx_st.pop_ok;

	always_comb begin
		tx_int_d = tx_int_q;
		unique case (op)
			uttq_pkg::OP_EVENT: begin
				if (echo_st.push_ok && echo_st.empty) begin
					tx_int_d = 1'b1;
				end
				if (tx_empty) begin
					tx_int_d = sent;
				end
			end
			uttq_pkg::OP_WRITE: begin
				tx_int_d = 1'b1;
			end
			default: begin
				tx_int_d = tx_int_q;
			end
		endcase
	end

	always_comb begin
		res_data        = '0;
		res_data[0]     = sent;
		res_data[8:1]   = echo_st.pop_ok ? echo_pop_data :
		                  (tx_st.pop_ok ? tx_pop_data : '0);
		res_data[9]     = rx_st.pop_ok;
		res_data[17:10] = rx_st.pop_ok ? rx_pop_data : '0;
		res_data[18]    = tx_st.push_ok;
		res_data[19]    = tx_int_d;
		res_data[20]    = rx_ctrl.push && !rx_st.push_ok;
		res_last        = s_axis_tlast && (tx_st.push_ok || rx_st.pop_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_en_q   <= 1'b1;
			tx_int_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				echo_en_q <= cfg_data;
			end
			if (accept) begin
				tx_int_q    <= tx_int_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= res_data;
			out_last_q <= res_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_tx_sets_irq: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[19])
		else $error("byte sent without transmit interrupt enable");

	a_one_sw_op: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[18]))
		else $error("read and write completed in one transaction");

	a_write_fills: assert property (@(posedge clk) disable iff (!arst_n)
		tx_st.push_ok |=> !tx_st.empty)
		else $error("transmit queue empty after accepted write");

	a_echo_first: assert property (@(posedge clk) disable iff (!arst_n)
		!(echo_st.pop_ok && tx_st.pop_ok))
		else $error("two queues sent in one transaction");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned QDEPTH         = 8;
	localparam int unsigned HOLD_CYCLES    = 200;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned PHASE_ITEMS    = 125;
	localparam int unsigned NUM_PHASES     = 6;

	// one input transaction, as software or the UART presents it
	typedef struct {
		uttq_pkg::op_t   op;
		logic            rx_ready;
		logic            tx_empty;
		uttq_pkg::byte_t rx_byte;
		uttq_pkg::byte_t write_byte;
		logic            final_byte;
	} tty_item_t;

	// m_axis_tdata layout, MSB first
	typedef struct packed {
		logic [2:0]      spare;
		logic            rx_dropped;
		logic            tx_irq_enable;
		logic            write_accepted;
		uttq_pkg::byte_t read_byte;
		logic            read_valid;
		uttq_pkg::byte_t tx_byte;
		logic            tx_valid;
	} tty_result_t;

	class tty_echo_scoreboard;
		uttq_pkg::byte_t rx_fifo[$];
		uttq_pkg::byte_t echo_fifo[$];
		uttq_pkg::byte_t tx_fifo[$];
		bit              tx_int_on = 1'b0;
		bit              echo_on = 1'b1;
		tty_result_t     want_data[$];
		bit              want_done[$];
		int unsigned     mismatches = 0;
		int unsigned     result_no = 0;

		function void set_echo(bit v);
			echo_on = v;
		endfunction

		function int unsigned pending();
			return want_data.size();
		endfunction

		// work out the result of one accepted transaction and queue it
		function void note_item(tty_item_t it);
			tty_result_t     r;
			bit              done;
			bit              sent;
			uttq_pkg::byte_t b;
			r    = '0;
			done = 1'b0;
			sent = 1'b0;
			b    = '0;
			case (it.op)
				uttq_pkg::OP_EVENT: begin
					if (it.rx_ready) begin
						if (rx_fifo.size() < QDEPTH) rx_fifo.push_back(it.rx_byte);
						else r.rx_dropped = 1'b1;
						// echo copy is lost silently when its queue is full
						if (echo_on && echo_fifo.size() < QDEPTH) begin
							echo_fifo.push_back(it.rx_byte);
							if (echo_fifo.size() == 1) tx_int_on = 1'b1;
						end
					end
					if (it.tx_empty) begin
						if (echo_fifo.size() != 0) begin
							b    = echo_fifo.pop_front();
							sent = 1'b1;
						end else if (tx_fifo.size() != 0) begin
							b    = tx_fifo.pop_front();
							sent = 1'b1;
						end
						if (sent) begin
							r.tx_valid = 1'b1;
							r.tx_byte  = b;
							tx_int_on  = 1'b1;
						end else begin
							tx_int_on = 1'b0;
						end
					end
				end
				uttq_pkg::OP_WRITE: begin
					if (tx_fifo.size() < QDEPTH) begin
						tx_fifo.push_back(it.write_byte);
						r.write_accepted = 1'b1;
						done = it.final_byte;
					end
					tx_int_on = 1'b1;
				end
				uttq_pkg::OP_READ: begin
					if (rx_fifo.size() != 0) begin
						r.read_valid = 1'b1;
						r.read_byte  = rx_fifo.pop_front();
						done = it.final_byte;
					end
				end
				default: ;
			endcase
			r.tx_irq_enable = tx_int_on;
			want_data.push_back(r);
			want_done.push_back(done);
		endfunction

		function void field_chk(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: %s expected %0h, got %0h", result_no, name, want, got);
			end
		endfunction

		function void check_result(logic [23:0] data, logic last);
			tty_result_t got;
			tty_result_t want;
			bit          done;
			got = data;
			if (want_data.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: no transaction waiting, got %0h", result_no, data);
			end else begin
				want = want_data.pop_front();
				done = want_done.pop_front();
				field_chk("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
				field_chk("tx_byte", want.tx_byte, got.tx_byte);
				field_chk("read_valid", 8'(want.read_valid), 8'(got.read_valid));
				field_chk("read_byte", want.read_byte, got.read_byte);
				field_chk("write_accepted", 8'(want.write_accepted), 8'(got.write_accepted));
				field_chk("tx_irq_enable", 8'(want.tx_irq_enable), 8'(got.tx_irq_enable));
				field_chk("rx_dropped", 8'(want.rx_dropped), 8'(got.rx_dropped));
				field_chk("spare bits", 8'(want.spare), 8'(got.spare));
				field_chk("request_done", 8'(done), 8'(last));
			end
			result_no++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_req = 1'b0;

	tty_echo_scoreboard sb = new();

	uart_tty_echo_queues #(
		.QUEUE_DEPTH(QDEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic tty_item_t mk_item(uttq_pkg::op_t op, logic rxr, logic txe,
			uttq_pkg::byte_t rxb, uttq_pkg::byte_t wb, logic fin);
		tty_item_t it;
		it.op         = op;
		it.rx_ready   = rxr;
		it.tx_empty   = txe;
		it.rx_byte    = rxb;
		it.write_byte = wb;
		it.final_byte = fin;
		return it;
	endfunction

	// filling favors received bytes and writes, otherwise reads and sends dominate
	function automatic tty_item_t rand_item(bit filling);
		tty_item_t   it;
		int unsigned pick;
		pick          = $urandom_range(99);
		it.rx_byte    = uttq_pkg::byte_t'($urandom_range(255));
		it.write_byte = uttq_pkg::byte_t'($urandom_range(255));
		it.final_byte = 1'($urandom_range(1));
		it.rx_ready   = $urandom_range(99) < (filling ? 80 : 30);
		it.tx_empty   = $urandom_range(99) < (filling ? 15 : 85);
		if (pick < 5) it.op = uttq_pkg::OP_NONE;
		else if (pick < (filling ? 55 : 50)) it.op = uttq_pkg::OP_EVENT;
		else if (pick < (filling ? 90 : 60)) it.op = uttq_pkg::OP_WRITE;
		else it.op = uttq_pkg::OP_READ;
		return it;
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_item(tty_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.op;
		s_axis_tdata  <= {6'b0, it.write_byte, it.rx_byte, it.tx_empty, it.rx_ready};
		s_axis_tlast  <= it.final_byte;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// only while idle: nothing offered and every result back
	task automatic write_echo(bit v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.set_echo(cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_item(mk_item(uttq_pkg::op_t'(s_axis_tuser), s_axis_tdata[0],
					s_axis_tdata[1], s_axis_tdata[9:2], s_axis_tdata[17:10], s_axis_tlast));
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		int unsigned send_pcts[NUM_PHASES]  = '{0, 46, 0, 9, 0, 9};
		int unsigned stall_pcts[NUM_PHASES] = '{0, 0, 46, 9, 0, 9};
		tty_item_t   it;
		int unsigned counted;
		bit          filling;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = uttq_pkg::OP_EVENT;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, echo on from reset
		// read with empty queue
		send_item(mk_item(uttq_pkg::OP_READ, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b1));
		// unused selector
		send_item(mk_item(uttq_pkg::OP_NONE, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b1));
		// nothing to send, irq off
		send_item(mk_item(uttq_pkg::OP_EVENT, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0));
		// echo to one entry, irq on
		send_item(mk_item(uttq_pkg::OP_EVENT, 1'b1, 1'b0, 8'h00, 8'hFF, 1'b1));
		for (int i = 0; i < 7; i++)
			send_item(mk_item(uttq_pkg::OP_EVENT, 1'b1, 1'b0,
				(i == 0) ? 8'hFF : uttq_pkg::byte_t'($urandom_range(255)), 8'h00, 1'b0));
		// receive and echo both full
		send_item(mk_item(uttq_pkg::OP_EVENT, 1'b1, 1'b0, 8'hA5, 8'h00, 1'b0));
		send_item(mk_item(uttq_pkg::OP_EVENT, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0));
		// receive full while echo has room
		send_item(mk_item(uttq_pkg::OP_EVENT, 1'b1, 1'b1, 8'h5A, 8'h00, 1'b1));
		for (int i = 0; i < 9; i++)
			send_item(mk_item(uttq_pkg::OP_WRITE, 1'b0, 1'b0, 8'h00,
				(i == 0) ? 8'h00 : (i == 1) ? 8'hFF : uttq_pkg::byte_t'($urandom_range(255)),
				(i == 1) || (i == 8)));
		send_item(mk_item(uttq_pkg::OP_READ, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1));
		send_item(mk_item(uttq_pkg::OP_EVENT, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0));

		filling = 1'b1;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_echo(1'(ph % 2));
			send_idle_pct  = send_pcts[ph];
			recv_stall_pct = stall_pcts[ph];
			// long output stall so the block backs up into its input
			if (ph == 4) hold_req = 1'b1;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				it = rand_item(filling);
				send_item(it);
				if (it.op != uttq_pkg::OP_NONE) begin
					counted++;
					if ($urandom_range(39) == 0) filling = !filling;
				end
			end
		end

		drain_results();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

/* files.f */
src/uttq_pkg.sv
src/uttq_cell.sv
src/uttq_fifo.sv
src/uart_tty_echo_queues.sv
sim/tb_top.sv
